[rtl/mbp_pkg.sv]
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int MAX_BITS  = 64;
    localparam int DATA_W    = 64;
    localparam int COUNT_W   = 7;
    localparam int PEND_W    = 7;
    localparam int PCNT_W    = 3;
    localparam int STREAM_W  = DATA_W + 8;
    localparam int LEFT_W    = 4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [DATA_W-1:0]    data_bits;
        logic [COUNT_W-1:0]   bit_count;
        logic                 fill_bit;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       error;
        logic       is_last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic shift;
    } mbp_cmd_t;

    typedef struct packed {
        logic has_result;
        logic last;
    } mbp_status_t;

endpackage

[rtl/mbp_ctrl.sv]
// ----------------------------------------------------------------------------
// mbp_ctrl
// Controller: takes one item at a time and paces result transfers.
// ----------------------------------------------------------------------------
module mbp_ctrl
    import mbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    output logic        res_valid,
    input  logic        res_stall,
    input  mbp_status_t status,
    output mbp_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    assign src_stall = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign cmd.load  = src_valid && (state_reg == ST_IDLE);
    assign cmd.shift = (state_reg == ST_EMIT) && !res_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && status.has_result)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.shift && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/mbp_dp.sv]
// ----------------------------------------------------------------------------
// mbp_dp
// Datapath: pending bits, aligned bit stream and byte output shifter.
// ----------------------------------------------------------------------------
module mbp_dp
    import mbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mbp_cmd_t    cmd,
    input  in_item_t    src_item,
    output mbp_status_t status,
    output out_item_t   res_item
);

    logic [STREAM_W-1:0] word_reg;
    logic [STREAM_W-1:0] word_next;
    logic [LEFT_W-1:0]   left_reg;
    logic [LEFT_W-1:0]   left_next;
    logic                err_reg;
    logic                err_next;
    logic [PEND_W-1:0]   pend_bits_reg;
    logic [PEND_W-1:0]   pend_bits_next;
    logic [PCNT_W-1:0]   pend_cnt_reg;
    logic [PCNT_W-1:0]   pend_cnt_next;

    logic [COUNT_W-1:0]  cnt_sat;
    logic [COUNT_W-1:0]  total;
    logic [LEFT_W-1:0]   nbytes;
    logic [PCNT_W-1:0]   rem;
    logic [STREAM_W-1:0] stream;
    logic [STREAM_W-1:0] tail;
    logic [PEND_W-1:0]   new_pend;
    logic [7:0]          flush_byte;
    logic                is_flush;
    logic                zero_cnt;
    logic                has_result;
    logic                last_res;

    assign is_flush = (src_item.action == ACT_FLUSH);
    assign zero_cnt = (src_item.bit_count == '0);
    assign cnt_sat  = (src_item.bit_count > COUNT_W'(MAX_BITS)) ?
                      COUNT_W'(MAX_BITS) : src_item.bit_count;
    assign total    = COUNT_W'(pend_cnt_reg) + cnt_sat;
    assign nbytes   = total[COUNT_W-1:3];
    assign rem      = total[2:0];

    // pending bits first, then data bits, left aligned
    assign stream   = ({pend_bits_reg, (STREAM_W-PEND_W)'(0)} << (PCNT_W'(7) - pend_cnt_reg))
                    | ({src_item.data_bits, 8'h00} >> pend_cnt_reg);
    assign tail     = stream << {nbytes, 3'b000};
    assign new_pend = tail[STREAM_W-1 -: PEND_W] >> (PCNT_W'(7) - rem);

    assign flush_byte = 8'({1'b0, pend_bits_reg} << (4'd8 - {1'b0, pend_cnt_reg}))
                      | (src_item.fill_bit ? (8'hFF >> pend_cnt_reg) : 8'h00);

    always_comb
    begin
        priority if (is_flush)
        begin
            has_result = (pend_cnt_reg != '0);
        end
        else if (zero_cnt)
        begin
            has_result = 1'b1;
        end
        else
        begin
            has_result = (nbytes != '0);
        end
    end

    assign last_res = (left_reg == LEFT_W'(1));
    assign status   = {has_result, last_res};

    always_comb
    begin
        word_next      = word_reg;
        left_next      = left_reg;
        err_next       = err_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        priority if (cmd.load)
        begin
            priority if (is_flush)
            begin
                word_next      = {flush_byte, (STREAM_W-8)'(0)};
                left_next      = (pend_cnt_reg != '0) ? LEFT_W'(1) : '0;
                err_next       = 1'b0;
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end
            else if (zero_cnt)
            begin
                word_next = '0;
                left_next = LEFT_W'(1);
                err_next  = 1'b1;
            end
            else
            begin
                word_next      = stream;
                left_next      = nbytes;
                err_next       = 1'b0;
                pend_bits_next = new_pend;
                pend_cnt_next  = rem;
            end
        end
        else if (cmd.shift)
        begin
            word_next = word_reg << 8;
            left_next = left_reg - LEFT_W'(1);
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else
        begin
            left_reg      <= left_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        err_reg  <= err_next;
    end

    assign res_item.out_byte = word_reg[STREAM_W-1 -: 8];
    assign res_item.error    = err_reg;
    assign res_item.is_last  = last_res;

endmodule

[rtl/msb_first_bit_packer_top.sv]
// ----------------------------------------------------------------------------
// msb_first_bit_packer_top
// Packs 1..64 bits per write, MSB first, into bytes; flush pads the tail.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------
//   src     | src_valid / src_stall | src_item (in_item_t)
//   res     | res_valid / res_stall | res_item (out_item_t)
//
// One item at a time: once an item is accepted, its results leave one
// byte per cycle from the output shifter while res_stall is low, with N
// results per item (0..8). Items causing no result leave the input free.
// res_stall holds the current byte; src_stall is high while results are out.
// Reset clears the pending bits and the controller.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_top
    import mbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  in_item_t  src_item,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_item
);

    mbp_cmd_t    cmd;
    mbp_status_t status;

    mbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mbp_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .src_item (src_item),
        .status   (status),
        .res_item (res_item)
    );

endmodule

[rtl/mbp_checker.sv]
// ----------------------------------------------------------------------------
// mbp_checker
// Port-level checks for the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module mbp_checker
    import mbp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      src_valid,
    input logic      src_stall,
    input in_item_t  src_item,
    input logic      res_valid,
    input logic      res_stall,
    input out_item_t res_item
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("stalled result changed");

    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall && src_item.action == ACT_WRITE &&
        src_item.bit_count == '0
        |=> res_valid && res_item.error && res_item.is_last)
        else $error("zero count write gave no error result");

    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.error |-> res_item.is_last && res_item.out_byte == 8'h00)
        else $error("malformed error result");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> src_stall)
        else $error("input taken while results pending");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && res_item.is_last |=> !res_valid)
        else $error("result after last transfer");

endmodule

bind msb_first_bit_packer_top mbp_checker u_mbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);

[tb/tb_msb_first_bit_packer_top.sv]
// ----------------------------------------------------------------------------
// tb_msb_first_bit_packer_top
// Self-checking bench for the MSB-first bit packer. A directed block hits
// count extremes, zero and saturated counts, flushes with either fill on empty
// and partial buffers, and full 71-bit spills. Random traffic then follows,
// with bursty idling on both channels and one long output hold-off. A
// bit-serial model predicts every byte, and each accepted transfer is compared
// in order against it.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_packer_top;
    import mbp_pkg::*;

    localparam int RAND_ITEMS    = 440;
    localparam int PRESSURE_AT   = 150;
    localparam int PRESSURE_LEN  = 30;
    localparam int TAIL_ITEMS    = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 20;

    class byte_stream_board;
        out_item_t         expected_bytes[$];
        logic [PEND_W-1:0] held_bits;
        int unsigned       held_count;
        int                errors;

        function new();
            held_bits  = '0;
            held_count = 0;
            errors     = 0;
        endfunction

        function void absorb_item(in_item_t it);
            out_item_t   r;
            out_item_t   prev;
            bit          have_prev;
            int unsigned n_bits;
            int unsigned pad;
            logic [7:0]  acc;
            if (it.action == ACT_FLUSH)
            begin
                if (held_count == 0)
                    return;
                pad = 8 - held_count;
                acc = {1'b0, held_bits} << pad;
                if (it.fill_bit)
                    acc = acc | ((8'd1 << pad) - 8'd1);
                r.out_byte = acc;
                r.error    = 1'b0;
                r.is_last  = 1'b1;
                expected_bytes.push_back(r);
                held_bits  = '0;
                held_count = 0;
                return;
            end
            if (it.bit_count == '0)
            begin
                r.out_byte = 8'h00;
                r.error    = 1'b1;
                r.is_last  = 1'b1;
                expected_bytes.push_back(r);
                return;
            end
            n_bits    = (it.bit_count > MAX_BITS) ? MAX_BITS : it.bit_count;
            acc       = {1'b0, held_bits};
            have_prev = 1'b0;
            for (int i = 0; i < n_bits; i++)
            begin
                acc = {acc[6:0], it.data_bits[DATA_W-1-i]};
                held_count++;
                if (held_count == 8)
                begin
                    if (have_prev)
                        expected_bytes.push_back(prev);
                    prev.out_byte = acc;
                    prev.error    = 1'b0;
                    prev.is_last  = 1'b0;
                    have_prev     = 1'b1;
                    acc           = 8'h00;
                    held_count    = 0;
                end
            end
            held_bits = acc[6:0];
            if (have_prev)
            begin
                prev.is_last = 1'b1;
                expected_bytes.push_back(prev);
            end
        endfunction

        function void check_byte(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual byte=%h error=%b last=%b",
                         $time, got.out_byte, got.error, got.is_last);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $display("%0t: out_byte mismatch, expected %h actual %h",
                         $time, want.out_byte, got.out_byte);
                errors++;
            end
            if (got.error !== want.error)
            begin
                $display("%0t: error mismatch, expected %b actual %b",
                         $time, want.error, got.error);
                errors++;
            end
            if (got.is_last !== want.is_last)
            begin
                $display("%0t: is_last mismatch, expected %b actual %b",
                         $time, want.is_last, got.is_last);
                errors++;
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    in_item_t  src_item  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_item_t res_item;

    bit hold_req  = 1'b0;
    bit tail_mode = 1'b0;

    byte_stream_board board = new();

    msb_first_bit_packer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
                board.absorb_item(src_item);
            if (res_valid && !res_stall)
                board.check_byte(res_item);
        end
    end

    task automatic send_item(input in_item_t it);
        src_valid <= 1'b1;
        src_item  <= it;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
    endtask

    task automatic send_write(input logic [DATA_W-1:0] data, input int count, input bit fill);
        in_item_t it;
        it.action    = ACT_WRITE;
        it.data_bits = data;
        it.bit_count = COUNT_W'(count);
        it.fill_bit  = fill;
        send_item(it);
    endtask

    task automatic send_flush(input bit fill);
        in_item_t it;
        it.action    = ACT_FLUSH;
        it.data_bits = {$urandom, $urandom};
        it.bit_count = COUNT_W'($urandom_range(0, 127));
        it.fill_bit  = fill;
        send_item(it);
    endtask

    function automatic in_item_t random_item();
        in_item_t it;
        int       sel;
        sel          = $urandom_range(0, 99);
        it.action    = ACT_WRITE;
        it.data_bits = {$urandom, $urandom};
        it.fill_bit  = $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0)
            it.data_bits = $urandom_range(0, 1) ? '1 : '0;
        if (sel < 16)
        begin
            it.action    = ACT_FLUSH;
            it.bit_count = COUNT_W'($urandom_range(0, 127));
        end
        else if (sel < 20)
            it.bit_count = '0;
        else if (sel < 28)
            it.bit_count = COUNT_W'($urandom_range(65, 127));
        else if (sel < 55)
            it.bit_count = COUNT_W'($urandom_range(1, 8));
        else
            it.bit_count = COUNT_W'($urandom_range(1, 64));
        return it;
    endfunction

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((src_valid && !src_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("msb_first_bit_packer_top verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (tail_mode)
            begin
                res_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                res_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        bit gaps_ok;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_flush(1'b1);
        send_write(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b1);
        send_write(64'h8000_0000_0000_0000, 1, 1'b1);
        send_flush(1'b0);
        send_write(64'hFE00_0000_0000_0000, 7, 1'b0);
        send_flush(1'b1);
        send_write(64'hA500_0000_0000_0000, 8, 1'b0);
        send_flush(1'b1);
        send_write(64'hFFFF_FFFF_FFFF_FFFF, 64, 1'b0);
        send_write(64'h0000_0000_0000_0000, 64, 1'b1);
        send_write(64'hE000_0000_0000_0000, 3, 1'b0);
        send_write(64'h0123_4567_89AB_CDEF, 64, 1'b0);
        send_write(64'h0000_0000_0000_0000, 0, 1'b0);
        send_flush(1'b0);
        send_write(64'hFE00_0000_0000_0000, 7, 1'b1);
        send_write(64'hFEDC_BA98_7654_3210, 64, 1'b0);
        send_flush(1'b0);
        send_write(64'h5555_5555_5555_5555, 127, 1'b1);
        send_write(64'hAAAA_AAAA_AAAA_AAAA, 65, 1'b0);
        send_write(64'h4000_0000_0000_0000, 2, 1'b0);
        send_flush(1'b1);
        send_flush(1'b0);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == PRESSURE_AT)
                hold_req = 1'b1;
            if (n == RAND_ITEMS - TAIL_ITEMS)
                tail_mode = 1'b1;
            gaps_ok = !tail_mode &&
                      !(n >= PRESSURE_AT && n < PRESSURE_AT + PRESSURE_LEN);
            if (gaps_ok && $urandom_range(0, 3) == 0)
            begin
                src_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            send_item(random_item());
        end
        src_valid <= 1'b0;

        while (board.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("msb_first_bit_packer_top verification clean");
        else
            $display("msb_first_bit_packer_top verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/mbp_pkg.sv
rtl/mbp_ctrl.sv
rtl/mbp_dp.sv
rtl/msb_first_bit_packer_top.sv
rtl/mbp_checker.sv
tb/tb_msb_first_bit_packer_top.sv
